/* sv/format_spec_char_classifier_unit_assert.svh */
// assertion macros used by the format spec classifier rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef FORMAT_SPEC_CHAR_CLASSIFIER_UNIT_ASSERT_SVH
`define FORMAT_SPEC_CHAR_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define FSCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fscc_pkg.sv */
// types, character codes and class helpers for the format spec classifier
// no dependencies
`default_nettype none

package fscc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FLAGS = 3'd1,
    PH_WIDTH = 3'd2,
    PH_PREC  = 3'd3,
    PH_LEN   = 3'd4,
    PH_KEY   = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    CLS_START   = 4'd0,
    CLS_NOTSPEC = 4'd1,
    CLS_FLAG    = 4'd2,
    CLS_WIDTH   = 4'd3,
    CLS_PREC    = 4'd4,
    CLS_LEN     = 4'd5,
    CLS_OPEN    = 4'd6,
    CLS_KEY     = 4'd7,
    CLS_CLOSE   = 4'd8,
    CLS_CONV    = 4'd9,
    CLS_DROP    = 4'd10,
    CLS_UNTERM  = 4'd11
  } cls_t;

  // what one character does to the parse
  typedef enum logic [3:0] {
    ACT_START,
    ACT_NOTSPEC,
    ACT_UNTERM,
    ACT_CLOSE,
    ACT_KEYCH,
    ACT_DBL,
    ACT_OPEN,
    ACT_FLAG,
    ACT_WDIG,
    ACT_DOT,
    ACT_PDIG,
    ACT_MOD,
    ACT_CONV
  } act_t;

  typedef struct packed {
    cls_t       char_class;
    logic [6:0] field_pos;
    logic       last;
    logic       split_valid;
    logic [6:0] split_pos;
  } res_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_J  = 8'h6A;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  function automatic logic is_flag(input logic [7:0] c);
    return c inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO, CH_QUOTE};
  endfunction

  function automatic logic is_mod(input logic [7:0] c);
    return c inside {CH_LOW_H, CH_LOW_L, CH_LOW_J, CH_LOW_Z, CH_LOW_T, CH_UP_L};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

endpackage

`default_nettype wire

/* sv/fscc_if.sv */
// valid/ready channel interfaces for the format spec classifier
// depends on nothing; payload widths follow the character and result fields
`default_nettype none

interface fscc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface fscc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] char_class;
  logic [6:0] field_pos;
  logic       last;
  logic       split_valid;
  logic [6:0] split_pos;

  modport source (output valid, output char_class, output field_pos, output last,
                  output split_valid, output split_pos, input ready);
  modport sink (input valid, input char_class, input field_pos, input last,
                input split_valid, input split_pos, output ready);
endinterface

`default_nettype wire

/* sv/fscc_in_stage.sv */
// input register of the format spec classifier: holds one character word
// uses no package items
`default_nettype none

module fscc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       take,
  output logic            item_valid,
  output logic [7:0]      item_ch
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] ch_r;
  logic       load;

  // slot is free when empty or when its word moves on this cycle
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r <= in_ch;
    end
  end

  assign item_valid = valid_r;
  assign item_ch    = ch_r;

endmodule

`default_nettype wire

/* sv/fscc_classify.sv */
// parse state and per-character classification of the format spec classifier
// depends on fscc_pkg and the assertion macro header
`default_nettype none
`include "format_spec_char_classifier_unit_assert.svh"

module fscc_classify #(
  parameter int FLAGS_SIZE     = 16,
  parameter int WIDTH_SIZE     = 16,
  parameter int PRECISION_SIZE = 16,
  parameter int MODIFIER_SIZE  = 8,
  parameter int KEYWORD_SIZE   = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire logic [7:0] ch,
  input  wire logic       fire,
  output fscc_pkg::res_t  res
);

  localparam int FW = $clog2(FLAGS_SIZE);
  localparam int WW = $clog2(WIDTH_SIZE);
  localparam int PW = $clog2(PRECISION_SIZE);
  localparam int MW = $clog2(MODIFIER_SIZE);
  localparam int KW = $clog2(KEYWORD_SIZE);

  // a field is full once its count reaches size - 1
  localparam logic [FW-1:0] FLAG_LIM = FW'(FLAGS_SIZE - 1);
  localparam logic [WW-1:0] WID_LIM  = WW'(WIDTH_SIZE - 1);
  localparam logic [PW-1:0] PREC_LIM = PW'(PRECISION_SIZE - 1);
  localparam logic [MW-1:0] MOD_LIM  = MW'(MODIFIER_SIZE - 1);
  localparam logic [KW-1:0] KEY_LIM  = KW'(KEYWORD_SIZE - 1);

  fscc_pkg::phase_t phase_r, phase_nxt;
  logic [FW-1:0]    flag_cnt_r, flag_cnt_nxt;
  logic [WW-1:0]    wid_cnt_r, wid_cnt_nxt;
  logic [PW-1:0]    prec_cnt_r, prec_cnt_nxt;
  logic [MW-1:0]    mod_cnt_r, mod_cnt_nxt;
  logic [KW-1:0]    kw_cnt_r, kw_cnt_nxt;
  logic             dbl_pend_r, dbl_pend_nxt;
  logic             dbl_is_l_r, dbl_is_l_nxt;
  logic             eq_found_r, eq_found_nxt;
  logic [6:0]       eq_pos_r, eq_pos_nxt;

  fscc_pkg::act_t act;
  logic flag_ok, wid_ok, prec_ok, mod_ok, kw_ok;
  logic in_fw;

  assign flag_ok = flag_cnt_r != FLAG_LIM;
  assign wid_ok  = wid_cnt_r != WID_LIM;
  assign prec_ok = prec_cnt_r != PREC_LIM;
  assign mod_ok  = mod_cnt_r != MOD_LIM;
  assign kw_ok   = kw_cnt_r != KEY_LIM;
  assign in_fw   = (phase_r == fscc_pkg::PH_FLAGS) || (phase_r == fscc_pkg::PH_WIDTH);

  // decode: which branch of the parse this character takes
  always_comb begin
    act = fscc_pkg::ACT_CONV;
    if (phase_r == fscc_pkg::PH_IDLE) begin
      act = (ch == fscc_pkg::CH_PCT) ? fscc_pkg::ACT_START : fscc_pkg::ACT_NOTSPEC;
    end else if (ch == fscc_pkg::CH_NUL) begin
      act = fscc_pkg::ACT_UNTERM;
    end else if (phase_r == fscc_pkg::PH_KEY) begin
      act = (ch == fscc_pkg::CH_RPAR) ? fscc_pkg::ACT_CLOSE : fscc_pkg::ACT_KEYCH;
    end else if (dbl_pend_r &&
                 ch == (dbl_is_l_r ? fscc_pkg::CH_LOW_L : fscc_pkg::CH_LOW_H)) begin
      act = fscc_pkg::ACT_DBL;
    end else if (ch == fscc_pkg::CH_LPAR) begin
      act = fscc_pkg::ACT_OPEN;
    end else if (phase_r == fscc_pkg::PH_FLAGS && fscc_pkg::is_flag(ch)) begin
      act = fscc_pkg::ACT_FLAG;
    end else if (in_fw && fscc_pkg::is_digit(ch)) begin
      act = fscc_pkg::ACT_WDIG;
    end else if (in_fw && ch == fscc_pkg::CH_DOT) begin
      act = fscc_pkg::ACT_DOT;
    end else if (phase_r == fscc_pkg::PH_PREC && fscc_pkg::is_digit(ch)) begin
      act = fscc_pkg::ACT_PDIG;
    end else if (fscc_pkg::is_mod(ch)) begin
      act = fscc_pkg::ACT_MOD;
    end
  end

  // next phase
  always_comb begin
    case (act)
      fscc_pkg::ACT_START:   phase_nxt = fscc_pkg::PH_FLAGS;
      fscc_pkg::ACT_NOTSPEC: phase_nxt = fscc_pkg::PH_IDLE;
      fscc_pkg::ACT_UNTERM:  phase_nxt = fscc_pkg::PH_IDLE;
      fscc_pkg::ACT_CLOSE:   phase_nxt = fscc_pkg::PH_FLAGS;
      fscc_pkg::ACT_KEYCH:   phase_nxt = fscc_pkg::PH_KEY;
      fscc_pkg::ACT_DBL:     phase_nxt = phase_r;
      fscc_pkg::ACT_OPEN:    phase_nxt = fscc_pkg::PH_KEY;
      fscc_pkg::ACT_FLAG:    phase_nxt = fscc_pkg::PH_FLAGS;
      fscc_pkg::ACT_WDIG:    phase_nxt = fscc_pkg::PH_WIDTH;
      fscc_pkg::ACT_DOT:     phase_nxt = fscc_pkg::PH_PREC;
      fscc_pkg::ACT_PDIG:    phase_nxt = fscc_pkg::PH_PREC;
      fscc_pkg::ACT_MOD:     phase_nxt = fscc_pkg::PH_LEN;
      fscc_pkg::ACT_CONV:    phase_nxt = fscc_pkg::PH_IDLE;
      default:               phase_nxt = fscc_pkg::PH_IDLE;
    endcase
  end

  // counters and keyword bookkeeping
  always_comb begin
    flag_cnt_nxt = flag_cnt_r;
    wid_cnt_nxt  = wid_cnt_r;
    prec_cnt_nxt = prec_cnt_r;
    mod_cnt_nxt  = mod_cnt_r;
    kw_cnt_nxt   = kw_cnt_r;
    dbl_pend_nxt = 1'b0;
    dbl_is_l_nxt = dbl_is_l_r;
    eq_found_nxt = eq_found_r;
    eq_pos_nxt   = eq_pos_r;
    case (act)
      fscc_pkg::ACT_START: begin
        flag_cnt_nxt = '0;
        wid_cnt_nxt  = '0;
        prec_cnt_nxt = '0;
        mod_cnt_nxt  = '0;
        kw_cnt_nxt   = '0;
        dbl_is_l_nxt = 1'b0;
        eq_found_nxt = 1'b0;
        eq_pos_nxt   = '0;
      end
      fscc_pkg::ACT_KEYCH: begin
        if (kw_ok) begin
          kw_cnt_nxt = kw_cnt_r + KW'(1);
          if (ch == fscc_pkg::CH_EQ && !eq_found_r) begin
            eq_found_nxt = 1'b1;
            eq_pos_nxt   = 7'(kw_cnt_r);
          end
        end
      end
      fscc_pkg::ACT_DBL: begin
        if (mod_ok) mod_cnt_nxt = mod_cnt_r + MW'(1);
      end
      fscc_pkg::ACT_OPEN: begin
        kw_cnt_nxt   = '0;
        eq_found_nxt = 1'b0;
        eq_pos_nxt   = '0;
      end
      fscc_pkg::ACT_FLAG: begin
        if (flag_ok) flag_cnt_nxt = flag_cnt_r + FW'(1);
      end
      fscc_pkg::ACT_WDIG: begin
        if (wid_ok) wid_cnt_nxt = wid_cnt_r + WW'(1);
      end
      fscc_pkg::ACT_DOT, fscc_pkg::ACT_PDIG: begin
        if (prec_ok) prec_cnt_nxt = prec_cnt_r + PW'(1);
      end
      fscc_pkg::ACT_MOD: begin
        if (mod_ok) begin
          mod_cnt_nxt = mod_cnt_r + MW'(1);
          // first length char h or l may be doubled
          if (mod_cnt_r == '0 &&
              (ch == fscc_pkg::CH_LOW_H || ch == fscc_pkg::CH_LOW_L)) begin
            dbl_pend_nxt = 1'b1;
            dbl_is_l_nxt = (ch == fscc_pkg::CH_LOW_L);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    res             = '0;
    res.char_class  = fscc_pkg::CLS_NOTSPEC;
    case (act)
      fscc_pkg::ACT_START: res.char_class = fscc_pkg::CLS_START;
      fscc_pkg::ACT_NOTSPEC: begin
        res.char_class = fscc_pkg::CLS_NOTSPEC;
        res.last       = 1'b1;
      end
      fscc_pkg::ACT_UNTERM: begin
        res.char_class = fscc_pkg::CLS_UNTERM;
        res.last       = 1'b1;
      end
      fscc_pkg::ACT_CLOSE: res.char_class = fscc_pkg::CLS_CLOSE;
      fscc_pkg::ACT_KEYCH: begin
        res.char_class = kw_ok ? fscc_pkg::CLS_KEY : fscc_pkg::CLS_DROP;
        res.field_pos  = kw_ok ? 7'(kw_cnt_r) : 7'd0;
      end
      fscc_pkg::ACT_DBL, fscc_pkg::ACT_MOD: begin
        res.char_class = mod_ok ? fscc_pkg::CLS_LEN : fscc_pkg::CLS_DROP;
        res.field_pos  = mod_ok ? 7'(mod_cnt_r) : 7'd0;
      end
      fscc_pkg::ACT_OPEN: res.char_class = fscc_pkg::CLS_OPEN;
      fscc_pkg::ACT_FLAG: begin
        res.char_class = flag_ok ? fscc_pkg::CLS_FLAG : fscc_pkg::CLS_DROP;
        res.field_pos  = flag_ok ? 7'(flag_cnt_r) : 7'd0;
      end
      fscc_pkg::ACT_WDIG: begin
        res.char_class = wid_ok ? fscc_pkg::CLS_WIDTH : fscc_pkg::CLS_DROP;
        res.field_pos  = wid_ok ? 7'(wid_cnt_r) : 7'd0;
      end
      fscc_pkg::ACT_DOT, fscc_pkg::ACT_PDIG: begin
        res.char_class = prec_ok ? fscc_pkg::CLS_PREC : fscc_pkg::CLS_DROP;
        res.field_pos  = prec_ok ? 7'(prec_cnt_r) : 7'd0;
      end
      fscc_pkg::ACT_CONV: begin
        res.char_class = fscc_pkg::CLS_CONV;
        res.last       = 1'b1;
        if (ch == fscc_pkg::CH_UP_T && kw_cnt_r != '0 && eq_found_r) begin
          res.split_valid = 1'b1;
          res.split_pos   = eq_pos_r;
        end
      end
      default: res.char_class = fscc_pkg::CLS_NOTSPEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= fscc_pkg::PH_IDLE;
      flag_cnt_r <= '0;
      wid_cnt_r  <= '0;
      prec_cnt_r <= '0;
      mod_cnt_r  <= '0;
      kw_cnt_r   <= '0;
      dbl_pend_r <= 1'b0;
      dbl_is_l_r <= 1'b0;
      eq_found_r <= 1'b0;
      eq_pos_r   <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      flag_cnt_r <= flag_cnt_nxt;
      wid_cnt_r  <= wid_cnt_nxt;
      prec_cnt_r <= prec_cnt_nxt;
      mod_cnt_r  <= mod_cnt_nxt;
      kw_cnt_r   <= kw_cnt_nxt;
      dbl_pend_r <= dbl_pend_nxt;
      dbl_is_l_r <= dbl_is_l_nxt;
      eq_found_r <= eq_found_nxt;
      eq_pos_r   <= eq_pos_nxt;
    end
  end

  `FSCC_ASSERT_IMP(a_last_class, item_valid && res.last,
    res.char_class == fscc_pkg::CLS_NOTSPEC || res.char_class == fscc_pkg::CLS_CONV ||
    res.char_class == fscc_pkg::CLS_UNTERM, "last set on a non-terminal class")
  `FSCC_ASSERT_NEXT(a_idle_after_last, fire && res.last,
    phase_r == fscc_pkg::PH_IDLE, "parse not idle after a final character")
  `FSCC_ASSERT_NEXT(a_start_clears, fire && act == fscc_pkg::ACT_START,
    kw_cnt_r == '0 && !eq_found_r && !dbl_pend_r, "percent did not clear state")
  `FSCC_ASSERT_IMP(a_split_conv, item_valid && res.split_valid,
    res.last && eq_found_r && kw_cnt_r != '0, "split reported without a kept equals")

endmodule

`default_nettype wire

/* sv/fscc_out_stage.sv */
// result register of the format spec classifier
// depends on fscc_pkg for the result word type
`default_nettype none

module fscc_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_valid,
  input  wire fscc_pkg::res_t res,
  output logic                take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fscc_pkg::res_t      out_res
);

  logic           valid_r;
  logic           valid_nxt;
  fscc_pkg::res_t res_r;
  logic           open_slot;

  // register takes a word when empty or being drained
  assign open_slot = !valid_r || out_ready;
  assign take      = item_valid && open_slot;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

/* sv/format_spec_char_classifier_unit.sv */
// channel   | dir | payload                                             | handshake
// in_ch     | in  | ch[7:0]                                             | valid/ready
// out_res   | out | char_class, field_pos, last, split_valid, split_pos | valid/ready
//
// one character word per clock while the result is not stalled, one result word per character
// data path: input register, then classification into the result register
// parse state updates when a character moves into the result register
// a stalled result holds; the input register keeps taking words until both are full
// synchronous active-low reset returns the parse to idle with all counts cleared
`default_nettype none

module format_spec_char_classifier_unit #(
  parameter int FLAGS_SIZE     = 16,
  parameter int WIDTH_SIZE     = 16,
  parameter int PRECISION_SIZE = 16,
  parameter int MODIFIER_SIZE  = 8,
  parameter int KEYWORD_SIZE   = 128
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fscc_in_if.sink     in_ch,
  fscc_out_if.source  out_res
);

  logic           take;
  logic           item_valid;
  logic [7:0]     item_ch;
  fscc_pkg::res_t res;
  fscc_pkg::res_t res_q;
  logic           res_valid;

  fscc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_ch      (in_ch.ch),
    .take       (take),
    .item_valid (item_valid),
    .item_ch    (item_ch)
  );

  fscc_classify #(
    .FLAGS_SIZE     (FLAGS_SIZE),
    .WIDTH_SIZE     (WIDTH_SIZE),
    .PRECISION_SIZE (PRECISION_SIZE),
    .MODIFIER_SIZE  (MODIFIER_SIZE),
    .KEYWORD_SIZE   (KEYWORD_SIZE)
  ) u_cls (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .ch         (item_ch),
    .fire       (take),
    .res        (res)
  );

  fscc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .take       (take),
    .out_valid  (res_valid),
    .out_ready  (out_res.ready),
    .out_res    (res_q)
  );

  assign out_res.valid       = res_valid;
  assign out_res.char_class  = res_q.char_class;
  assign out_res.field_pos   = res_q.field_pos;
  assign out_res.last        = res_q.last;
  assign out_res.split_valid = res_q.split_valid;
  assign out_res.split_pos   = res_q.split_pos;

endmodule

`default_nettype wire

/* verif/format_spec_char_classifier_unit_tb.sv */
// self-checking bench for format_spec_char_classifier_unit: streams format characters through
// the valid/ready channels, predicts each result word and compares it; needs fscc_pkg and fscc_if
module format_spec_char_classifier_unit_tb;
  import fscc_pkg::*;

  localparam int FLAGS_CAP     = 16;
  localparam int WIDTH_CAP     = 16;
  localparam int PRECISION_CAP = 16;
  localparam int MODIFIER_CAP  = 8;
  localparam int KEYWORD_CAP   = 128;
  localparam int N_ITEMS       = 700;
  localparam int DRAIN_EVERY   = 250;

  // character sources for the random specs
  localparam int SRC_FLAG  = 0;
  localparam int SRC_DIGIT = 1;
  localparam int SRC_MOD   = 2;

  logic clk = 1'b0;
  logic rst_n;

  fscc_in_if  in_if();
  fscc_out_if out_if();

  format_spec_char_classifier_unit #(
    .FLAGS_SIZE    (FLAGS_CAP),
    .WIDTH_SIZE    (WIDTH_CAP),
    .PRECISION_SIZE(PRECISION_CAP),
    .MODIFIER_SIZE (MODIFIER_CAP),
    .KEYWORD_SIZE  (KEYWORD_CAP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_res(out_if)
  );

  always #2 clk = ~clk;

  logic [7:0]  char_backlog [$];
  logic [7:0]  spec_q [$];
  res_t        expected_results [$];
  int unsigned n_items = 1;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_split = 0;
  int unsigned class_hits [16];

  logic [7:0] flag_chars [6] = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO, CH_QUOTE};
  logic [7:0] mod_chars [6] = '{CH_LOW_H, CH_LOW_L, CH_LOW_J, CH_LOW_Z, CH_LOW_T, CH_UP_L};
  logic [7:0] conv_chars [10] = '{"d", "i", "o", "u", "x", "X", "s", "c", "p", CH_PCT};

  // parse state of the classifier as the bench sees it
  phase_t      parse_phase = PH_IDLE;
  int unsigned n_flags, n_width, n_prec, n_mods, n_key, eq_index;
  logic        dbl_pending, dbl_ell, eq_seen;

  function automatic void clear_counts();
    n_flags = 0;
    n_width = 0;
    n_prec = 0;
    n_mods = 0;
    n_key = 0;
    eq_index = 0;
    dbl_pending = 1'b0;
    dbl_ell = 1'b0;
    eq_seen = 1'b0;
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // a character is kept only while one slot of the field stays free
  function automatic cls_t keep_char(inout int unsigned cnt, input int unsigned cap,
                                     input cls_t hit, output logic [6:0] pos);
    if (cnt + 1 < cap) begin
      pos = cnt[6:0];
      cnt++;
      return hit;
    end
    pos = '0;
    return CLS_DROP;
  endfunction

  function automatic res_t classify_char(input logic [7:0] c);
    res_t        r;
    logic [6:0]  pos;
    logic        was_pending;
    logic        placed;
    int unsigned at;
    r = '0;
    r.char_class = CLS_NOTSPEC;
    pos = '0;
    placed = 1'b0;
    was_pending = dbl_pending;
    dbl_pending = 1'b0;
    if (parse_phase == PH_IDLE) begin
      if (c == CH_PCT) begin
        clear_counts();
        parse_phase = PH_FLAGS;
        r.char_class = CLS_START;
      end else begin
        r.last = 1'b1;
      end
    end else if (c == CH_NUL) begin
      r.char_class = CLS_UNTERM;
      r.last = 1'b1;
      parse_phase = PH_IDLE;
    end else if (parse_phase == PH_KEY) begin
      if (c == CH_RPAR) begin
        r.char_class = CLS_CLOSE;
        parse_phase = PH_FLAGS;
      end else begin
        at = n_key;
        r.char_class = keep_char(n_key, KEYWORD_CAP, CLS_KEY, pos);
        if (r.char_class == CLS_KEY && c == CH_EQ && !eq_seen) begin
          eq_seen = 1'b1;
          eq_index = at;
        end
      end
    end else if (was_pending && c == (dbl_ell ? CH_LOW_L : CH_LOW_H)) begin
      // second half of hh or ll, taken before the open-paren and field tests
      r.char_class = keep_char(n_mods, MODIFIER_CAP, CLS_LEN, pos);
    end else if (c == CH_LPAR) begin
      r.char_class = CLS_OPEN;
      n_key = 0;
      eq_seen = 1'b0;
      eq_index = 0;
      parse_phase = PH_KEY;
    end else begin
      if (parse_phase == PH_FLAGS) begin
        if (c == CH_MINUS || c == CH_PLUS || c == CH_SPACE || c == CH_HASH ||
            c == CH_ZERO || c == CH_QUOTE) begin
          r.char_class = keep_char(n_flags, FLAGS_CAP, CLS_FLAG, pos);
          placed = 1'b1;
        end else begin
          parse_phase = PH_WIDTH;
        end
      end
      if (!placed && parse_phase == PH_WIDTH) begin
        if (digit_char(c)) begin
          r.char_class = keep_char(n_width, WIDTH_CAP, CLS_WIDTH, pos);
          placed = 1'b1;
        end else if (c == CH_DOT) begin
          // a dot moves on to precision even when it is dropped
          r.char_class = keep_char(n_prec, PRECISION_CAP, CLS_PREC, pos);
          parse_phase = PH_PREC;
          placed = 1'b1;
        end else begin
          parse_phase = PH_LEN;
        end
      end
      if (!placed && parse_phase == PH_PREC) begin
        if (digit_char(c)) begin
          r.char_class = keep_char(n_prec, PRECISION_CAP, CLS_PREC, pos);
          placed = 1'b1;
        end else begin
          parse_phase = PH_LEN;
        end
      end
      if (!placed) begin
        if (c == CH_LOW_H || c == CH_LOW_L || c == CH_LOW_J || c == CH_LOW_Z ||
            c == CH_LOW_T || c == CH_UP_L) begin
          r.char_class = keep_char(n_mods, MODIFIER_CAP, CLS_LEN, pos);
          if (r.char_class == CLS_LEN && n_mods == 1 && (c == CH_LOW_H || c == CH_LOW_L)) begin
            dbl_pending = 1'b1;
            dbl_ell = (c == CH_LOW_L);
          end
        end else begin
          r.char_class = CLS_CONV;
          r.last = 1'b1;
          parse_phase = PH_IDLE;
          if (c == CH_UP_T && n_key != 0 && eq_seen) begin
            r.split_valid = 1'b1;
            r.split_pos = eq_index[6:0];
          end
        end
      end
    end
    r.field_pos = pos;
    return r;
  endfunction

  // stimulus helpers

  function automatic logic [7:0] pick(input int src);
    if (src == SRC_FLAG) return flag_chars[$urandom_range(0, 5)];
    if (src == SRC_MOD) return mod_chars[$urandom_range(0, 5)];
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // a short run, or with a chance of long_pct percent one around the field capacity
  function automatic int unsigned run_len(input int unsigned long_pct, input int unsigned cap);
    if ($urandom_range(0, 99) < long_pct) return $urandom_range(cap - 2, cap + 2);
    return $urandom_range(0, 3);
  endfunction

  task automatic add_run(input int src, input int unsigned len);
    repeat (len) spec_q.push_back(pick(src));
  endtask

  task automatic add_keyword();
    int unsigned len;
    int unsigned eq_at;
    int unsigned i;
    int unsigned sel;
    logic [7:0]  b;
    len = ($urandom_range(0, 99) < 6) ? $urandom_range(KEYWORD_CAP - 3, KEYWORD_CAP + 2)
                                      : $urandom_range(0, 8);
    eq_at = ($urandom_range(0, 99) < 50 && len != 0) ? $urandom_range(0, len - 1) : len;
    spec_q.push_back(CH_LPAR);
    for (i = 0; i < len; i++) begin
      sel = $urandom_range(0, 99);
      if (i == eq_at) begin
        b = CH_EQ;
      end else if (sel < 60) begin
        b = 8'($urandom_range(8'h61, 8'h7A));
      end else if (sel < 70) begin
        b = CH_LPAR;
      end else begin
        b = 8'($urandom_range(1, 255));
        if (b == CH_RPAR) b = CH_EQ;
      end
      spec_q.push_back(b);
    end
    spec_q.push_back(CH_RPAR);
  endtask

  task automatic build_spec();
    logic        two_rounds;
    int unsigned r;
    int unsigned sel;
    int unsigned cut;
    logic [7:0]  m;
    spec_q.delete();
    spec_q.push_back(CH_PCT);
    two_rounds = ($urandom_range(0, 99) < 20);
    // a second round follows a keyword, where the counts carry over
    for (r = 0; r <= 32'(two_rounds); r++) begin
      if (r == 1 || $urandom_range(0, 99) < 20) add_keyword();
      add_run(SRC_FLAG, run_len(10, FLAGS_CAP));
      add_run(SRC_DIGIT, run_len(10, WIDTH_CAP));
      if ((two_rounds && r == 0) || $urandom_range(0, 99) < (r == 1 ? 80 : 50)) begin
        spec_q.push_back(CH_DOT);
        add_run(SRC_DIGIT, run_len((two_rounds && r == 0) ? 40 : 10, PRECISION_CAP));
      end
    end
    if ($urandom_range(0, 99) < 20) add_keyword();
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      spec_q.push_back(pick(SRC_MOD));
    end else if (sel < 65) begin
      m = $urandom_range(0, 1) ? CH_LOW_L : CH_LOW_H;
      repeat ((sel < 55) ? 2 : 3) spec_q.push_back(m);
    end else if (sel < 75) begin
      add_run(SRC_MOD, run_len(100, MODIFIER_CAP));
    end
    if ($urandom_range(0, 99) < 10) add_keyword();
    sel = $urandom_range(0, 99);
    if (sel < 8) spec_q.push_back(CH_NUL);
    else if (sel < 33) spec_q.push_back(CH_UP_T);
    else if (sel < 38) spec_q.push_back(8'($urandom_range(0, 255)));
    else spec_q.push_back(conv_chars[$urandom_range(0, 9)]);
    // broken spec: cut short by a terminator
    if ($urandom_range(0, 99) < 10) begin
      cut = $urandom_range(1, spec_q.size() - 1);
      while (spec_q.size() > cut) void'(spec_q.pop_back());
      spec_q.push_back(CH_NUL);
    end
  endtask

  // stall percentage for each third of the run
  function automatic int unsigned idle_pct(input logic sender_side);
    int unsigned stage;
    stage = n_sent * 3 / n_items;
    if (stage == 0) return sender_side ? 23 : 55;
    if (stage == 1) return sender_side ? 55 : 23;
    return 0;
  endfunction

  task automatic check_field(input string fld, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
    end
  endtask

  // driver: one word at a time from the backlog
  always @(posedge clk) begin
    logic nxt_valid;
    logic hold;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      nxt_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(classify_char(in_if.ch));
        n_sent++;
        nxt_valid = 1'b0;
      end
      // now and then let the pipe run empty before sending more
      hold = (n_sent % DRAIN_EVERY == 0) && (n_sent != 0) && (expected_results.size() != 0);
      if (!nxt_valid && char_backlog.size() != 0 && !hold &&
          $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        in_if.ch <= char_backlog.pop_front();
        nxt_valid = 1'b1;
      end
      in_if.valid <= nxt_valid;
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual class %0d pos %0d",
                   $time, out_if.char_class, out_if.field_pos);
        end else begin
          want = expected_results.pop_front();
          check_field("char_class", want.char_class, out_if.char_class);
          check_field("field_pos", want.field_pos, out_if.field_pos);
          check_field("last", want.last, out_if.last);
          check_field("split_valid", want.split_valid, out_if.split_valid);
          check_field("split_pos", want.split_pos, out_if.split_pos);
          class_hits[want.char_class]++;
          if (want.split_valid) n_split++;
          n_checked++;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  initial begin
    logic [7:0] opening [] = '{
      8'hFF, CH_NUL,
      CH_PCT, CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO, CH_QUOTE, CH_NINE, CH_DOT, "5",
      CH_LOW_H, CH_LOW_H, CH_LPAR, "a", CH_LPAR, CH_EQ, CH_RPAR, CH_UP_T,
      CH_PCT, CH_LPAR, CH_EQ, CH_RPAR, CH_LPAR, CH_RPAR, CH_LOW_L, CH_UP_T,
      CH_PCT, CH_LPAR, CH_NUL
    };
    in_if.valid = 1'b0;
    in_if.ch = '0;
    out_if.ready = 1'b0;
    rst_n = 1'b0;
    clear_counts();
    foreach (class_hits[i]) class_hits[i] = 0;

    foreach (opening[i]) char_backlog.push_back(opening[i]);
    while (char_backlog.size() < N_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) char_backlog.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_spec();
        foreach (spec_q[i]) char_backlog.push_back(spec_q[i]);
      end
    end
    n_items = char_backlog.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent != n_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d words in, %0d results checked, %0d conversions (%0d split), %0d dropped",
             n_sent, n_checked, class_hits[CLS_CONV], n_split, class_hits[CLS_DROP]);
    $display("     %0d unterminated, %0d not a spec, %0d keyword characters",
             class_hits[CLS_UNTERM], class_hits[CLS_NOTSPEC], class_hits[CLS_KEY]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
